/* src/tsp_pkg.sv */
// Shared types and constants for the tach speed PI motor controller.
`default_nettype none
package tsp_pkg;

  // Event kinds carried in the input tuser field.
  typedef enum logic [1:0] {
    OP_TACH  = 2'd0,
    OP_OVF   = 2'd1,
    OP_TICK  = 2'd2,
    OP_SERIAL = 2'd3
  } tsp_op_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_INT_COEFF  = 3'd1,
    REG_TRK_COEFF  = 3'd2,
    REG_SPEED_NUM  = 3'd3,
    REG_SPEED_OFS  = 3'd4,
    REG_FLOOR_DUTY = 3'd5
  } tsp_reg_e;

  // Width of the serial multiply-accumulate register.
  localparam int unsigned ACC_W   = 56;
  // Width of the multiplier coefficients.
  localparam int unsigned COEFF_W = 16;
  // Width of the signed speed and error values.
  localparam int unsigned SPD_W   = 18;
  // Serial byte that asks for a speed report.
  localparam logic [7:0] QUERY_BYTE = 8'hff;

  // Control word from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic start;  // load operands and begin
    logic keep;   // add onto the present sum instead of the initial value
  } tsp_mac_ctrl_t;

endpackage
`default_nettype wire

/* src/tsp_div.sv */
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module tsp_div #(
  parameter int unsigned W = 19
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] dividend_i,
  input  wire logic [15:0]  divisor_i,
  output logic      [W-1:0] quotient_o,
  output logic              done_o
);

  localparam int unsigned CW = $clog2(W + 1);

  logic [16:0]   rem_q;
  logic [W-1:0]  quo_q;
  logic [15:0]   dvs_q;
  logic [CW-1:0] cnt_q;
  logic          done_q;

  logic [16:0] shifted;
  logic [17:0] diff;
  logic        ge;

  // One trial subtraction of the shifted partial remainder.
  always_comb begin
    shifted = {rem_q[15:0], quo_q[W-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs_q};
    ge      = ~diff[17];
  end

  // Control: bit counter and done pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= !start_i && (cnt_q == CW'(1));
      if (start_i) begin
        cnt_q <= CW'(W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Datapath: remainder and dividend/quotient shift register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? diff[16:0] : shifted;
      quo_q <= {quo_q[W-2:0], ge};
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule
`default_nettype wire

/* src/tsp_mac.sv */
// Shift-and-add multiply-accumulate, one coefficient bit per cycle.
`default_nettype none
module tsp_mac (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire tsp_pkg::tsp_mac_ctrl_t              ctrl_i,
  input  wire logic signed [tsp_pkg::ACC_W-1:0]    init_i,
  input  wire logic signed [tsp_pkg::ACC_W-1:0]    mcand_i,
  input  wire logic        [tsp_pkg::COEFF_W-1:0]  coeff_i,
  output logic signed      [tsp_pkg::ACC_W-1:0]    acc_o,
  output logic                                     done_o
);

  localparam int unsigned CW = $clog2(tsp_pkg::COEFF_W + 1);

  logic signed [tsp_pkg::ACC_W-1:0]   acc_q;
  logic signed [tsp_pkg::ACC_W-1:0]   m_q;
  logic        [tsp_pkg::COEFF_W-1:0] c_q;
  logic        [CW-1:0]               cnt_q;
  logic                               done_q;

  // Control: bit counter and done pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= !ctrl_i.start && (cnt_q == CW'(1));
      if (ctrl_i.start) begin
        cnt_q <= CW'(tsp_pkg::COEFF_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Datapath: add the shifted multiplicand for each set coefficient bit.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      if (!ctrl_i.keep) begin
        acc_q <= init_i;
      end
      m_q <= mcand_i;
      c_q <= coeff_i;
    end else if (cnt_q != '0) begin
      if (c_q[0]) begin
        acc_q <= acc_q + m_q;
      end
      m_q <= m_q <<< 1;
      c_q <= c_q >> 1;
    end
  end

  assign acc_o  = acc_q;
  assign done_o = done_q;

endmodule
`default_nettype wire

/* src/tach_speed_pi_motor_controller.sv */
// Top level: event sequencer, period ring, speed measurement and PI step.
//
//  Channel   Direction  Contents (lowest bit first)
//  s_axis    in         tdata: period_count[15:0], rx_byte[23:16]; tuser: op[1:0]
//  m_axis    out        tdata: pwm_compare[7:0], tx_byte[15:8], speed_now[32:16];
//                       tuser: tx_valid
//  cfg       in         write enable, register index, 16-bit data
//
// Timer overflows, serial bytes and even-position tach edges go straight to ST_DONE.
// A tach edge at an odd position sweeps the ring and runs the serial divider for the
// average and, unless the average is zero, once more for the speed.
// A control tick runs three passes of the serial multiplier.
// After reset the ring reads as zero, speed is 0 and the compare value is 255.
// A result waits in ST_DONE until the output register is free; no word is taken there.
`default_nettype none
module tach_speed_pi_motor_controller #(
  parameter int unsigned RING_DEPTH = 8,
  parameter int unsigned FRAC_BITS  = 12
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [23:0] s_axis_tdata_i,   // period_count, rx_byte
  input  wire logic [1:0]  s_axis_tuser_i,   // op
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [39:0]      m_axis_tdata_o,   // pwm_compare, tx_byte, speed_now
  output logic             m_axis_tuser_o,   // tx_valid
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int unsigned RW  = $clog2(RING_DEPTH);
  localparam int unsigned CW  = $clog2(RING_DEPTH + 1);
  localparam int unsigned SW  = 16 + RW;
  localparam int unsigned AW  = tsp_pkg::ACC_W;
  localparam int unsigned SPW = tsp_pkg::SPD_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SWEEP, ST_AVG_GO, ST_AVG_WAIT, ST_SPD_GO, ST_SPD_WAIT,
    ST_P_GO, ST_P_WAIT, ST_LIMIT, ST_I_GO, ST_I_WAIT, ST_T_GO, ST_T_WAIT,
    ST_SAT, ST_DONE
  } state_e;

  // Configuration registers.
  logic [15:0] prop_gain_q, int_coeff_q, trk_coeff_q, speed_num_q;
  logic [7:0]  speed_ofs_q, floor_duty_q;

  // Control state.
  state_e                state_q;
  logic [RW-1:0]         pos_q;
  logic [RING_DEPTH-1:0] valid_q;
  logic [CW-1:0]         cnt_q;
  logic signed [SPW-1:0] speed_q;
  logic [7:0]            ref_q;
  logic signed [31:0]    integ_q;
  logic [7:0]            cmp_q;
  logic                  tx_q;
  logic [7:0]            txb_q;
  logic                  out_valid_q;
  logic [7:0]            out_cmp_q, out_txb_q;
  logic                  out_tx_q;
  logic [16:0]           out_spd_q;

  // Payload registers.
  logic [15:0]           ring_mem [RING_DEPTH];
  logic [15:0]           rd_q;
  logic [SW-1:0]         sum_q;
  logic [15:0]           avg_q;
  logic signed [AW-1:0]  dv_q;

  // Word fields.
  tsp_pkg::tsp_op_e op;
  logic [15:0]      period_in;
  logic [7:0]       rx_in;
  logic             accept;
  logic             query;
  logic             out_load;

  assign op        = tsp_pkg::tsp_op_e'(s_axis_tuser_i);
  assign period_in = s_axis_tdata_i[15:0];
  assign rx_in     = s_axis_tdata_i[23:16];
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept    = s_axis_tvalid_i && s_axis_tready_o;
  assign query     = (op == tsp_pkg::OP_SERIAL) && (rx_in == tsp_pkg::QUERY_BYTE);
  assign out_load  = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready_i);

  // Divider and multiplier hookup.
  logic                 div_start, div_done;
  logic [SW-1:0]        div_dividend, div_quo;
  logic [15:0]          div_divisor;
  tsp_pkg::tsp_mac_ctrl_t mac_ctrl;
  logic signed [AW-1:0] mac_init, mac_mcand, mac_acc;
  logic [15:0]          mac_coeff;
  logic                 mac_done;

  logic signed [SPW-1:0] err;
  logic signed [AW-1:0]  err_ext, integ_ext;

  always_comb begin
    err       = $signed({{(SPW-8){1'b0}}, ref_q}) - speed_q;
    err_ext   = {{(AW-SPW){err[SPW-1]}}, err};
    integ_ext = {{(AW-32){integ_q[31]}}, integ_q};
  end

  always_comb begin
    div_start    = (state_q == ST_AVG_GO) || (state_q == ST_SPD_GO && avg_q != '0);
    div_dividend = (state_q == ST_AVG_GO) ? sum_q : {{(SW-16){1'b0}}, speed_num_q};
    div_divisor  = (state_q == ST_AVG_GO) ? 16'(RING_DEPTH) : avg_q;
  end

  always_comb begin
    mac_ctrl.start = (state_q == ST_P_GO) || (state_q == ST_I_GO) || (state_q == ST_T_GO);
    mac_ctrl.keep  = (state_q == ST_T_GO);
    mac_init       = integ_ext;
    mac_mcand      = (state_q == ST_T_GO) ? dv_q : err_ext;
    case (state_q)
      ST_P_GO: mac_coeff = prop_gain_q;
      ST_I_GO: mac_coeff = int_coeff_q;
      default: mac_coeff = trk_coeff_q;
    endcase
  end

  tsp_div #(.W(SW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quo),
    .done_o     (div_done)
  );

  tsp_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mac_ctrl),
    .init_i  (mac_init),
    .mcand_i (mac_mcand),
    .coeff_i (mac_coeff),
    .acc_o   (mac_acc),
    .done_o  (mac_done)
  );

  // Output limiting: shift toward zero, clamp, floor duty.
  logic signed [AW-1:0] p_mag, v_mag, v_val;
  logic [7:0]           duty;
  always_comb begin
    p_mag = mac_acc[AW-1] ? -mac_acc : mac_acc;
    v_mag = p_mag >>> FRAC_BITS;
    v_val = mac_acc[AW-1] ? -v_mag : v_mag;
    if (v_val[AW-1]) begin
      duty = (ref_q != '0) ? floor_duty_q : 8'd0;
    end else if (v_val > AW'(255)) begin
      duty = 8'hff;
    end else begin
      duty = v_val[7:0];
    end
  end

  // Integrator saturation to the signed 32-bit range.
  logic [31:0] integ_sat;
  always_comb begin
    if (mac_acc[AW-1] && !(&mac_acc[AW-1:31])) begin
      integ_sat = 32'h8000_0000;
    end else if (!mac_acc[AW-1] && (|mac_acc[AW-1:31])) begin
      integ_sat = 32'h7fff_ffff;
    end else begin
      integ_sat = mac_acc[31:0];
    end
  end

  logic [RW-1:0] pos_next;
  assign pos_next = (pos_q == RW'(RING_DEPTH - 1)) ? '0 : pos_q + 1'b1;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q  <= 16'd2212;
      int_coeff_q  <= 16'd737;
      trk_coeff_q  <= 16'd1365;
      speed_num_q  <= 16'd39063;
      speed_ofs_q  <= 8'd2;
      floor_duty_q <= 8'd4;
    end else if (cfg_we_i) begin
      case (tsp_pkg::tsp_reg_e'(cfg_idx_i))
        tsp_pkg::REG_PROP_GAIN:  prop_gain_q  <= cfg_data_i;
        tsp_pkg::REG_INT_COEFF:  int_coeff_q  <= cfg_data_i;
        tsp_pkg::REG_TRK_COEFF:  trk_coeff_q  <= cfg_data_i;
        tsp_pkg::REG_SPEED_NUM:  speed_num_q  <= cfg_data_i;
        tsp_pkg::REG_SPEED_OFS:  speed_ofs_q  <= cfg_data_i[7:0];
        tsp_pkg::REG_FLOOR_DUTY: floor_duty_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Period ring memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (accept && (op == tsp_pkg::OP_TACH || op == tsp_pkg::OP_OVF)) begin
      ring_mem[pos_q] <= (op == tsp_pkg::OP_TACH) ? period_in : 16'd0;
    end
    rd_q <= ring_mem[cnt_q[RW-1:0]];
  end

  // Sequencer and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      valid_q     <= '0;
      cnt_q       <= '0;
      speed_q     <= '0;
      ref_q       <= '0;
      integ_q     <= '0;
      cmp_q       <= 8'hff;
      tx_q        <= 1'b0;
      txb_q       <= '0;
      out_valid_q <= 1'b0;
      out_cmp_q   <= '0;
      out_txb_q   <= '0;
      out_tx_q    <= 1'b0;
      out_spd_q   <= '0;
      sum_q       <= '0;
      avg_q       <= '0;
      dv_q        <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            tx_q  <= query;
            txb_q <= query ? speed_q[7:0] : 8'd0;
            case (op)
              tsp_pkg::OP_TACH: begin
                valid_q[pos_q] <= 1'b1;
                pos_q          <= pos_next;
                cnt_q          <= '0;
                sum_q          <= '0;
                state_q        <= pos_q[0] ? ST_SWEEP : ST_DONE;
              end
              tsp_pkg::OP_OVF: begin
                valid_q[pos_q] <= 1'b1;
                pos_q          <= pos_next;
                speed_q        <= '0;
                state_q        <= ST_DONE;
              end
              tsp_pkg::OP_TICK: begin
                state_q <= ST_P_GO;
              end
              default: begin
                if (rx_in != tsp_pkg::QUERY_BYTE) begin
                  ref_q <= rx_in;
                end
                state_q <= ST_DONE;
              end
            endcase
          end
        end
        // Sum the ring one entry per cycle; rd_q holds the entry before the index.
        ST_SWEEP: begin
          if (cnt_q != '0 && valid_q[cnt_q[RW-1:0] - 1'b1]) begin
            sum_q <= sum_q + SW'(rd_q);
          end
          if (cnt_q == CW'(RING_DEPTH)) begin
            state_q <= ST_AVG_GO;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_AVG_GO: state_q <= ST_AVG_WAIT;
        ST_AVG_WAIT: begin
          if (div_done) begin
            avg_q   <= div_quo[15:0];
            state_q <= ST_SPD_GO;
          end
        end
        ST_SPD_GO: begin
          if (avg_q == '0) begin
            speed_q <= SPW'(65535);
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_SPD_WAIT;
          end
        end
        ST_SPD_WAIT: begin
          if (div_done) begin
            speed_q <= $signed({2'b00, div_quo[15:0]}) -
                       $signed({{(SPW-8){1'b0}}, speed_ofs_q});
            state_q <= ST_DONE;
          end
        end
        ST_P_GO: state_q <= ST_P_WAIT;
        ST_P_WAIT: begin
          if (mac_done) begin
            state_q <= ST_LIMIT;
          end
        end
        ST_LIMIT: begin
          cmp_q   <= ~duty;
          dv_q    <= $signed({{(AW-8){1'b0}}, duty}) - v_val;
          state_q <= ST_I_GO;
        end
        ST_I_GO: state_q <= ST_I_WAIT;
        ST_I_WAIT: begin
          if (mac_done) begin
            state_q <= ST_T_GO;
          end
        end
        ST_T_GO: state_q <= ST_T_WAIT;
        ST_T_WAIT: begin
          if (mac_done) begin
            state_q <= ST_SAT;
          end
        end
        ST_SAT: begin
          integ_q <= integ_sat;
          state_q <= ST_DONE;
        end
        // Hand the result to the output register once it is free.
        ST_DONE: begin
          if (out_load) begin
            out_cmp_q   <= cmp_q;
            out_tx_q    <= tx_q;
            out_txb_q   <= txb_q;
            out_spd_q   <= speed_q[16:0];
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_spd_q, out_txb_q, out_cmp_q};
  assign m_axis_tuser_o  = out_tx_q;

endmodule
`default_nettype wire

/* test/tsp_checker.sv */
// Checker for the tach speed PI motor controller: predicts each result word and compares it.
`timescale 1ns / 100ps
`default_nettype none
module tsp_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [23:0] in_data_i,   // period_count, rx_byte
  input  wire logic [1:0]  in_user_i,   // op
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic [39:0] out_data_i,  // pwm_compare, tx_byte, speed_now
  input  wire logic        out_user_i,  // tx_valid
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  output int               fail_count_o,
  output int               pending_o
);

  typedef struct packed {
    logic [7:0]  compare;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic [16:0] speed;
  } motor_word_t;

  motor_word_t expected_words[$];

  logic [15:0] kp, ki, kt, numer;
  logic [7:0]  ofs, floor_d;
  logic [15:0] periods [8];
  logic [2:0]  slot;
  longint      speed_m;
  logic [7:0]  ref_v;
  longint      integ;
  logic [7:0]  cmp;

  // Applies one event to the predicted state and returns the word it yields.
  function automatic motor_word_t apply_event(logic [1:0] op, logic [15:0] per,
                                              logic [7:0] rx);
    motor_word_t w;
    longint sum, avg, err, p, v, duty, acc;
    w = '0;
    case (tsp_pkg::tsp_op_e'(op))
      tsp_pkg::OP_TACH: begin
        periods[slot] = per;
        if (slot[0]) begin
          sum = 0;
          for (int i = 0; i < 8; i++) sum += periods[i];
          avg = sum / 8;
          if (avg == 0) speed_m = 65535;
          else speed_m = longint'(numer) / avg - longint'(ofs);
        end
        slot = slot + 3'd1;
      end
      tsp_pkg::OP_OVF: begin
        periods[slot] = '0;
        slot = slot + 3'd1;
        speed_m = 0;
      end
      tsp_pkg::OP_TICK: begin
        err = longint'(ref_v) - speed_m;
        p = integ + longint'(kp) * err;
        v = (p >= 0) ? (p >>> 12) : -((-p) >>> 12);
        if (v > 255) duty = 255;
        else if (v < 0) duty = (ref_v != 0) ? longint'(floor_d) : 0;
        else duty = v;
        cmp = duty[7:0] ^ 8'hff;
        acc = integ + longint'(ki) * err + longint'(kt) * (duty - v);
        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
        if (acc < -64'sd2147483648) acc = -64'sd2147483648;
        integ = acc;
      end
      default: begin
        if (rx == tsp_pkg::QUERY_BYTE) begin
          w.tx_valid = 1'b1;
          w.tx_byte = speed_m[7:0];
        end else begin
          ref_v = rx;
        end
      end
    endcase
    w.compare = cmp;
    w.speed = speed_m[16:0];
    return w;
  endfunction

  assign pending_o = expected_words.size();

  // Tracks configuration, predicts accepted words and checks results.
  always @(posedge clk_i or negedge rst_ni) begin
    motor_word_t got, exp_w;
    if (!rst_ni) begin
      kp = 16'd2212; ki = 16'd737; kt = 16'd1365; numer = 16'd39063;
      ofs = 8'd2; floor_d = 8'd4;
      for (int i = 0; i < 8; i++) periods[i] = '0;
      slot = '0; speed_m = 0; ref_v = '0; integ = 0; cmp = 8'hff;
      expected_words.delete();
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (tsp_pkg::tsp_reg_e'(cfg_idx_i))
          tsp_pkg::REG_PROP_GAIN:  kp = cfg_data_i;
          tsp_pkg::REG_INT_COEFF:  ki = cfg_data_i;
          tsp_pkg::REG_TRK_COEFF:  kt = cfg_data_i;
          tsp_pkg::REG_SPEED_NUM:  numer = cfg_data_i;
          tsp_pkg::REG_SPEED_OFS:  ofs = cfg_data_i[7:0];
          tsp_pkg::REG_FLOOR_DUTY: floor_d = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        expected_words.push_back(apply_event(in_user_i, in_data_i[15:0], in_data_i[23:16]));
      if (out_valid_i && out_ready_i) begin
        got.compare = out_data_i[7:0];
        got.tx_byte = out_data_i[15:8];
        got.speed = out_data_i[32:16];
        got.tx_valid = out_user_i;
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected");
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_w = expected_words.pop_front();
          if (got != exp_w) fail_count_o <= fail_count_o + 1;
          if (got.compare != exp_w.compare)
            $error("pwm_compare expected %0d actual %0d", exp_w.compare, got.compare);
          if (got.tx_valid != exp_w.tx_valid)
            $error("tx_valid expected %0d actual %0d", exp_w.tx_valid, got.tx_valid);
          if (got.tx_byte != exp_w.tx_byte)
            $error("tx_byte expected %0d actual %0d", exp_w.tx_byte, got.tx_byte);
          if (got.speed != exp_w.speed)
            $error("speed_now expected %0d actual %0d", exp_w.speed, got.speed);
        end
      end
    end
  end

endmodule
`default_nettype wire

/* test/tb_tach_speed_pi_motor_controller.sv */
// Testbench top for the tach speed PI motor controller: stimulus, watchdog and verdict.
`timescale 1ns / 100ps
`default_nettype none
module tb_tach_speed_pi_motor_controller;

  localparam int STALL_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [23:0] s_data = '0;
  logic [1:0]  s_user = '0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [39:0] m_data;
  logic        m_user;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [15:0] cfg_data = '0;
  int          fail_count, pending;
  int          idle_cycles = 0;
  bit          calm = 1'b0;
  bit          hold_out = 1'b0;

  tach_speed_pi_motor_controller u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready),
    .s_axis_tdata_i(s_data), .s_axis_tuser_i(s_user),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data), .m_axis_tuser_o(m_user),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  tsp_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(s_valid), .in_ready_i(s_ready), .in_data_i(s_data), .in_user_i(s_user),
    .out_valid_i(m_valid), .out_ready_i(m_ready), .out_data_i(m_data),
    .out_user_i(m_user),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Watchdog on cycles with no accepted word on either side.
  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: random stall bursts, a long hold-off on request, none when calm.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_out) begin
        m_ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_out = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 8);
        m_ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end else begin
        m_ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Sends one word, with a random gap before it unless calm.
  task automatic send_word(logic [1:0] op, logic [15:0] per, logic [7:0] rx);
    if (!calm && $urandom_range(0, 4) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user <= op;
    s_data <= {rx, per};
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
  endtask

  // Waits until every expected word is back and the block has settled.
  task automatic drain();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(tsp_pkg::tsp_reg_e idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random event mix; tach edges dominate so speed updates often, ticks drive the loop.
  task automatic random_events(int count, int per_max);
    int k;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 99);
      if (k < 45)
        send_word(tsp_pkg::OP_TACH, 16'($urandom_range(0, per_max)), 8'($urandom));
      else if (k < 50)
        send_word(tsp_pkg::OP_OVF, 16'($urandom), 8'($urandom));
      else if (k < 80)
        send_word(tsp_pkg::OP_TICK, 16'($urandom), 8'($urandom));
      else if (k < 90)
        send_word(tsp_pkg::OP_SERIAL, 16'($urandom), tsp_pkg::QUERY_BYTE);
      else
        send_word(tsp_pkg::OP_SERIAL, 16'($urandom), 8'($urandom_range(0, 254)));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero average saturates speed, query, reference, extreme periods.
    send_word(tsp_pkg::OP_TICK, 16'h0000, 8'h00);
    send_word(tsp_pkg::OP_SERIAL, 16'hffff, tsp_pkg::QUERY_BYTE);
    send_word(tsp_pkg::OP_TACH, 16'h0000, 8'h00);
    send_word(tsp_pkg::OP_TACH, 16'h0000, 8'h00);
    send_word(tsp_pkg::OP_SERIAL, 16'h0000, tsp_pkg::QUERY_BYTE);
    send_word(tsp_pkg::OP_SERIAL, 16'h0000, 8'd254);
    send_word(tsp_pkg::OP_TICK, 16'h0000, 8'h00);
    for (int i = 0; i < 8; i++) send_word(tsp_pkg::OP_TACH, 16'hffff, 8'hff);
    send_word(tsp_pkg::OP_TICK, 16'h0000, 8'h00);
    send_word(tsp_pkg::OP_OVF, 16'hffff, 8'hff);
    send_word(tsp_pkg::OP_SERIAL, 16'h0000, 8'h00);
    send_word(tsp_pkg::OP_TICK, 16'h0000, 8'h00);
    send_word(tsp_pkg::OP_SERIAL, 16'h0000, 8'd1);
    send_word(tsp_pkg::OP_TACH, 16'd40, 8'h00);
    send_word(tsp_pkg::OP_TACH, 16'd40, 8'h00);
    send_word(tsp_pkg::OP_TICK, 16'h0000, 8'h00);
    send_word(tsp_pkg::OP_SERIAL, 16'h0000, tsp_pkg::QUERY_BYTE);
    drain();

    // Default settings, with a long receiver hold-off to back up the block.
    hold_out = 1'b1;
    random_events(350, 2000);
    drain();

    // Extremes: maximum gains and offsets, saturating the integrator.
    write_reg(tsp_pkg::REG_PROP_GAIN, 16'hffff);
    write_reg(tsp_pkg::REG_INT_COEFF, 16'hffff);
    write_reg(tsp_pkg::REG_TRK_COEFF, 16'hffff);
    write_reg(tsp_pkg::REG_SPEED_NUM, 16'hffff);
    write_reg(tsp_pkg::REG_SPEED_OFS, 16'h00ff);
    write_reg(tsp_pkg::REG_FLOOR_DUTY, 16'h00ff);
    random_events(300, 65535);
    drain();

    // Minimum settings.
    write_reg(tsp_pkg::REG_PROP_GAIN, 16'h0000);
    write_reg(tsp_pkg::REG_INT_COEFF, 16'h0000);
    write_reg(tsp_pkg::REG_TRK_COEFF, 16'h0000);
    write_reg(tsp_pkg::REG_SPEED_NUM, 16'h0001);
    write_reg(tsp_pkg::REG_SPEED_OFS, 16'h0000);
    write_reg(tsp_pkg::REG_FLOOR_DUTY, 16'h0000);
    random_events(200, 16);
    drain();

    // Random mid-range settings.
    write_reg(tsp_pkg::REG_PROP_GAIN, 16'($urandom_range(0, 8191)));
    write_reg(tsp_pkg::REG_INT_COEFF, 16'($urandom_range(0, 2047)));
    write_reg(tsp_pkg::REG_TRK_COEFF, 16'($urandom_range(0, 4095)));
    write_reg(tsp_pkg::REG_SPEED_NUM, 16'($urandom_range(1, 65535)));
    write_reg(tsp_pkg::REG_SPEED_OFS, 16'($urandom_range(0, 255)));
    write_reg(tsp_pkg::REG_FLOOR_DUTY, 16'($urandom_range(0, 255)));
    random_events(450, 4000);

    // Closing stretch without idling.
    calm = 1'b1;
    random_events(230, 65535);
    drain();

    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
src/tsp_pkg.sv
src/tsp_div.sv
src/tsp_mac.sv
src/tach_speed_pi_motor_controller.sv
test/tsp_checker.sv
test/tb_tach_speed_pi_motor_controller.sv
